### hw/rtl/mcd_pkg.sv
// ----------------------------------------------------------------------------
// mcd_pkg
// Shared types and constants for the multi-click / long-press detector.
// ----------------------------------------------------------------------------
package mcd_pkg;

    // Defaults for top-level parameters
    localparam int MAX_OUTPUTS_DEF = 16;
    localparam int TIME_BITS_DEF   = 16;

    // Field and register widths
    localparam int TIMEOUT_W   = 16;
    localparam int OUTPUTS_W   = 5;
    localparam int INDEX_W     = 4;
    localparam int COUNT_W     = 8;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;
    // Compare domain for output counts: holds up to 511 outputs
    localparam int OUTS_CMP_W  = 9;

    // Reset values of the configuration registers
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(1000);
    localparam logic [OUTPUTS_W-1:0] OUTPUTS_RST = OUTPUTS_W'(2);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUTS = CFG_IDX_W'(1);

    // Input command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Configuration seen by the core
    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout_ticks;
        logic [OUTPUTS_W-1:0] outputs_in_use;
    } cfg_t;

    // One result produced by the core
    typedef struct packed {
        logic               valid;
        logic [INDEX_W-1:0] index;
        logic               value;
    } result_t;

endpackage

### hw/rtl/mcd_cfg_regs.sv
// ----------------------------------------------------------------------------
// mcd_cfg_regs
// Configuration register file: window timeout and number of outputs.
// ----------------------------------------------------------------------------
module mcd_cfg_regs
    import mcd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic [OUTPUTS_W-1:0] outputs_reg, outputs_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        timeout_next = timeout_reg;
        outputs_next = outputs_reg;
        if (cfg_valid) begin
            if (cfg_index == REG_TIMEOUT) begin
                timeout_next = cfg_data[TIMEOUT_W-1:0];
            end else if (cfg_index == REG_OUTPUTS) begin
                outputs_next = cfg_data[OUTPUTS_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RST;
            outputs_reg <= OUTPUTS_RST;
        end else begin
            timeout_reg <= timeout_next;
            outputs_reg <= outputs_next;
        end
    end

    assign cfg.timeout_ticks  = timeout_reg;
    assign cfg.outputs_in_use = outputs_reg;

endmodule

### hw/rtl/mcd_core.sv
// ----------------------------------------------------------------------------
// mcd_core
// Button state, click counting and window timing; decides at most one result per item.
// ----------------------------------------------------------------------------
module mcd_core
    import mcd_pkg::*;
#(
    parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    item_valid,
    input  logic    command,
    input  logic    pressed,
    input  cfg_t    cfg,
    output result_t result
);

    localparam int LIM_W = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;
    localparam logic [TIME_BITS-1:0]  TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [LIM_W-1:0]      TIME_MAX_L = LIM_W'(TIME_MAX);
    localparam logic [OUTS_CMP_W-1:0] NOUT_MAX = OUTS_CMP_W'(MAX_OUTPUTS);
    localparam logic [OUTS_CMP_W-1:0] NOUT_TWO = OUTS_CMP_W'(2);
    localparam logic [COUNT_W-1:0]    COUNT_MAX = {COUNT_W{1'b1}};

    logic                 held_reg, held_next;
    logic                 long_held_reg, long_held_next;
    logic                 window_open_reg, window_open_next;
    logic [COUNT_W-1:0]   press_count_reg, press_count_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;

    logic [OUTS_CMP_W-1:0] outs_wide;
    logic [OUTS_CMP_W-1:0] nout;
    logic [OUTS_CMP_W-1:0] count_wide;
    logic [OUTS_CMP_W-1:0] click_idx;
    logic [LIM_W-1:0]      limit;
    logic [LIM_W-1:0]      timeout_wide;
    logic [TIME_BITS-1:0]  elapsed_inc;

    // Clamp the output count to 1..MAX_OUTPUTS
    always_comb begin
        outs_wide = OUTS_CMP_W'(cfg.outputs_in_use);
        if (outs_wide == '0) begin
            nout = OUTS_CMP_W'(1);
        end else if (outs_wide > NOUT_MAX) begin
            nout = NOUT_MAX;
        end else begin
            nout = outs_wide;
        end
    end

    // Window limit: zero acts as one tick, saturate at the counter maximum
    always_comb begin
        timeout_wide = LIM_W'(cfg.timeout_ticks);
        if (timeout_wide == '0) begin
            limit = LIM_W'(1);
        end else if (timeout_wide > TIME_MAX_L) begin
            limit = TIME_MAX_L;
        end else begin
            limit = timeout_wide;
        end
    end

    assign elapsed_inc = (elapsed_reg < TIME_MAX) ? elapsed_reg + TIME_BITS'(1) : elapsed_reg;
    assign count_wide  = OUTS_CMP_W'(press_count_reg);
    assign click_idx   = (count_wide >= nout) ? nout - OUTS_CMP_W'(1) : count_wide;

    always_comb begin
        held_next        = held_reg;
        long_held_next   = long_held_reg;
        window_open_next = window_open_reg;
        press_count_next = press_count_reg;
        elapsed_next     = elapsed_reg;
        result           = '0;
        if (item_valid) begin
            if (command == CMD_SAMPLE) begin
                if (pressed) begin
                    held_next    = 1'b1;
                    elapsed_next = '0;
                    if (!window_open_reg) begin
                        window_open_next = 1'b1;
                        press_count_next = COUNT_W'(1);
                    end else if (press_count_reg != COUNT_MAX) begin
                        press_count_next = press_count_reg + COUNT_W'(1);
                    end
                end else if (held_reg) begin
                    held_next = 1'b0;
                    if (long_held_reg) begin
                        long_held_next = 1'b0;
                        result.valid   = 1'b1;
                        result.index   = '0;
                        result.value   = 1'b0;
                    end else if (nout == NOUT_TWO) begin
                        result.valid = 1'b1;
                        result.index = INDEX_W'(1);
                        result.value = 1'b1;
                    end
                end
            end else if (window_open_reg) begin
                elapsed_next = elapsed_inc;
                if (LIM_W'(elapsed_inc) >= limit) begin
                    window_open_next = 1'b0;
                    elapsed_next     = '0;
                    if (held_reg) begin
                        long_held_next = 1'b1;
                    end
                    result.index = held_reg ? '0 : click_idx[INDEX_W-1:0];
                    result.value = 1'b1;
                    result.valid = held_reg || long_held_reg || (nout > NOUT_TWO);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg        <= 1'b0;
            long_held_reg   <= 1'b0;
            window_open_reg <= 1'b0;
            press_count_reg <= '0;
            elapsed_reg     <= '0;
        end else begin
            held_reg        <= held_next;
            long_held_reg   <= long_held_next;
            window_open_reg <= window_open_next;
            press_count_reg <= press_count_next;
            elapsed_reg     <= elapsed_next;
        end
    end

    // A long press can only be marked while the button is down
    a_long_implies_held: assert property (@(posedge aclk) disable iff (!aresetn)
        long_held_reg |-> held_reg)
        else $error("long press marked while button released");

    // The tick counter rests at zero whenever no window is open
    a_idle_elapsed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !window_open_reg |-> (elapsed_reg == '0))
        else $error("tick counter running with window closed");

    // An open window has counted at least one press
    a_open_has_press: assert property (@(posedge aclk) disable iff (!aresetn)
        window_open_reg |-> (press_count_reg != '0))
        else $error("window open with no press counted");

endmodule

### hw/rtl/mcd_out_fifo.sv
// ----------------------------------------------------------------------------
// mcd_out_fifo
// Two-entry result buffer; decouples the core from result backpressure.
// ----------------------------------------------------------------------------
module mcd_out_fifo
    import mcd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  logic [INDEX_W-1:0] push_index,
    input  logic               push_value,
    output logic               room,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [INDEX_W-1:0] m_out_index,
    output logic               m_out_value
);

    localparam int DEPTH = 2;

    logic [INDEX_W-1:0] index_reg [DEPTH];
    logic               value_reg [DEPTH];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    logic               pop;

    assign room        = (count_reg != 2'(DEPTH));
    assign m_valid     = (count_reg != '0);
    assign pop         = m_valid && m_ready;
    assign m_out_index = index_reg[rd_ptr_reg];
    assign m_out_value = value_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            index_reg[wr_ptr_reg] <= push_index;
            value_reg[wr_ptr_reg] <= push_value;
        end
    end

endmodule

### hw/rtl/multi_click_long_press_detector.sv
// ----------------------------------------------------------------------------
// multi_click_long_press_detector
// Counts button clicks inside a timed window and flags long presses.
// ----------------------------------------------------------------------------
// Path: an accepted beat is registered in the input register; the core decision
//   for it is written into the result buffer once there is room, then m_valid rises.
// Throughput: one input beat per cycle, as the core updates on every held beat;
//   s_ready stays high while the result side takes every beat, and drops
//   while the two-entry result buffer is full and a beat is held.
// Reset: aresetn is synchronous, active low; clears button and window state,
//   empties the buffer and loads timeout 1000 ticks and two outputs.
// ----------------------------------------------------------------------------
module multi_click_long_press_detector
    import mcd_pkg::*;
#(
    parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input channel: button sample or time tick
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic                  s_pressed,
    // Result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [INDEX_W-1:0]    m_out_index,
    output logic                  m_out_value
);

    cfg_t    cfg;
    result_t result;

    // Input register: holds one accepted beat until the core consumes it
    logic in_valid_reg, in_valid_next;
    logic in_command_reg;
    logic in_pressed_reg;

    logic room;
    logic consume;
    logic s_accept;

    // Consume the held beat whenever the buffer can take a possible result
    assign consume  = in_valid_reg && room;
    // Take a new beat when the input register is empty or drains this cycle
    assign s_ready  = !in_valid_reg || consume;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload needs no reset; load on every accepted beat
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_command_reg <= s_command;
            in_pressed_reg <= s_pressed;
        end
    end

    mcd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Decide the result of the held beat and advance button state
    mcd_core #(
        .MAX_OUTPUTS (MAX_OUTPUTS),
        .TIME_BITS   (TIME_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (consume),
        .command    (in_command_reg),
        .pressed    (in_pressed_reg),
        .cfg        (cfg),
        .result     (result)
    );

    // Buffer results; drop nothing, the core only runs when there is room
    mcd_out_fifo u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (result.valid),
        .push_index  (result.index),
        .push_value  (result.value),
        .room        (room),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_index (m_out_index),
        .m_out_value (m_out_value)
    );

    // A result is only produced for a beat that is being consumed
    a_result_needs_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        result.valid |-> (in_valid_reg && room))
        else $error("result produced without a consumed beat");

    // A held beat that cannot drain blocks new input
    a_block_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !room) |-> !s_ready)
        else $error("input accepted while held beat is blocked");

    // A consumed beat with no new accept leaves the input register empty
    a_drain_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && !s_accept) |=> !in_valid_reg)
        else $error("input register not cleared after consume");

endmodule

### bench/tb.sv
// ============================================================================
// tb
// Self-checking bench for the multi-click / long-press detector. A directed
// script covers the reset state, zero and clamped settings and long presses.
// Random click bursts, long presses and noise follow under changing settings,
// with random idling on both channels. Results are checked in order against
// a behavioral copy of the detector's button and window state.
// ============================================================================
module tb;
    import mcd_pkg::*;

    // Widths and limits of the instance (default parameters)
    localparam int TIME_MAX = 2**TIME_BITS_DEF - 1;
    localparam int OUTS_MAX = MAX_OUTPUTS_DEF;
    localparam int OUTS_TOP = 2**OUTPUTS_W - 1;
    // Settling margin after the results drain, covering a beat with no result
    localparam int HOLD_OFF = 4;
    // Register indexes that map to nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_OUTPUTS + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

    // Button levels on a sample beat
    localparam logic BTN_DOWN = 1'b1;
    localparam logic BTN_UP   = 1'b0;

    // How a beat's result is known: from the predictor, or typed in
    typedef enum logic [1:0] {NOTE_PREDICT, NOTE_QUIET, NOTE_FIRE} note_kind_t;
    typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               value;
    } click_event_t;

    typedef struct packed {
        note_kind_t         kind;
        logic [INDEX_W-1:0] index;
        logic               value;
    } note_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic                  cmd;
        logic                  prs;
        note_t                 note;
    } dir_row_t;

    localparam note_t BY_MODEL  = '{NOTE_PREDICT, 4'd0, 1'b0};
    localparam note_t NO_RESULT = '{NOTE_QUIET, 4'd0, 1'b0};

    // Directed script. Typed results only where they are obvious; the rest
    // go through the predictor.
    localparam int NUM_ROWS = 32;
    localparam dir_row_t SCRIPT [NUM_ROWS] = '{
        // reset settings: timeout 1000, two outputs
        '{ROW_BEAT, REG_TIMEOUT, 16'h0000, CMD_TICK,   BTN_DOWN, NO_RESULT},
        '{ROW_BEAT, REG_TIMEOUT, 16'h0000, CMD_SAMPLE, BTN_UP,   NO_RESULT},
        '{ROW_BEAT, REG_TIMEOUT, 16'h0000, CMD_SAMPLE, BTN_DOWN, NO_RESULT},
        '{ROW_BEAT, REG_TIMEOUT, 16'h0000, CMD_SAMPLE, BTN_UP,   '{NOTE_FIRE, 4'd1, 1'b1}},
        // zero timeout behaves as one tick
        '{ROW_CFG,  REG_TIMEOUT, 16'h0000, CMD_SAMPLE, BTN_UP,   BY_MODEL},
        '{ROW_BEAT, REG_TIMEOUT, 16'h0000, CMD_SAMPLE, BTN_DOWN, NO_RESULT},
        '{ROW_BEAT, REG_TIMEOUT, 16'h0000, CMD_TICK,   BTN_UP,   '{NOTE_FIRE, 4'd0, 1'b1}},
        '{ROW_BEAT, REG_TIMEOUT, 16'h0000, CMD_SAMPLE, BTN_DOWN, NO_RESULT},
        '{ROW_BEAT, REG_TIMEOUT, 16'h0000, CMD_TICK,   BTN_UP,   '{NOTE_FIRE, 4'd0, 1'b1}},
        '{ROW_BEAT, REG_TIMEOUT, 16'h0000, CMD_SAMPLE, BTN_UP,   '{NOTE_FIRE, 4'd0, 1'b0}},
        // multi-click with the most outputs; a write to an unmapped index
        '{ROW_CFG,  REG_TIMEOUT,  16'h0002, CMD_SAMPLE, BTN_UP,   BY_MODEL},
        '{ROW_CFG,  REG_OUTPUTS,  16'h0010, CMD_SAMPLE, BTN_UP,   BY_MODEL},
        '{ROW_CFG,  REG_SPARE_HI, 16'hFFFF, CMD_SAMPLE, BTN_UP,   BY_MODEL},
        '{ROW_BEAT, REG_TIMEOUT,  16'h0000, CMD_SAMPLE, BTN_DOWN, BY_MODEL},
        '{ROW_BEAT, REG_TIMEOUT,  16'h0000, CMD_SAMPLE, BTN_UP,   BY_MODEL},
        '{ROW_BEAT, REG_TIMEOUT,  16'h0000, CMD_SAMPLE, BTN_DOWN, BY_MODEL},
        '{ROW_BEAT, REG_TIMEOUT,  16'h0000, CMD_SAMPLE, BTN_UP,   BY_MODEL},
        '{ROW_BEAT, REG_TIMEOUT,  16'h0000, CMD_SAMPLE, BTN_DOWN, BY_MODEL},
        '{ROW_BEAT, REG_TIMEOUT,  16'h0000, CMD_TICK,   BTN_DOWN, BY_MODEL},
        '{ROW_BEAT, REG_TIMEOUT,  16'h0000, CMD_SAMPLE, BTN_UP,   BY_MODEL},
        '{ROW_BEAT, REG_TIMEOUT,  16'h0000, CMD_TICK,   BTN_UP,   BY_MODEL},
        // zero outputs clamps to one; upper data bits must be dropped
        '{ROW_CFG,  REG_OUTPUTS,  16'hFFE0, CMD_SAMPLE, BTN_UP,   BY_MODEL},
        '{ROW_BEAT, REG_TIMEOUT,  16'h0000, CMD_SAMPLE, BTN_DOWN, BY_MODEL},
        '{ROW_BEAT, REG_TIMEOUT,  16'h0000, CMD_SAMPLE, BTN_UP,   BY_MODEL},
        '{ROW_BEAT, REG_TIMEOUT,  16'h0000, CMD_TICK,   BTN_UP,   BY_MODEL},
        '{ROW_BEAT, REG_TIMEOUT,  16'h0000, CMD_TICK,   BTN_DOWN, BY_MODEL},
        // outputs above the maximum clamp; press while already held
        '{ROW_CFG,  REG_OUTPUTS,  16'h001F, CMD_SAMPLE, BTN_UP,   BY_MODEL},
        '{ROW_CFG,  REG_TIMEOUT,  16'h0001, CMD_SAMPLE, BTN_UP,   BY_MODEL},
        '{ROW_BEAT, REG_TIMEOUT,  16'h0000, CMD_SAMPLE, BTN_DOWN, BY_MODEL},
        '{ROW_BEAT, REG_TIMEOUT,  16'h0000, CMD_SAMPLE, BTN_DOWN, BY_MODEL},
        '{ROW_BEAT, REG_TIMEOUT,  16'h0000, CMD_TICK,   BTN_UP,   '{NOTE_FIRE, 4'd0, 1'b1}},
        '{ROW_BEAT, REG_TIMEOUT,  16'h0000, CMD_SAMPLE, BTN_UP,   '{NOTE_FIRE, 4'd0, 1'b0}}
    };

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known level
    // ------------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic                  s_command = CMD_SAMPLE;
    logic                  s_pressed = BTN_UP;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [INDEX_W-1:0]    m_out_index;
    logic                  m_out_value;

    // Travels with the payload so the checker knows how to judge the beat
    note_t beat_note = BY_MODEL;

    multi_click_long_press_detector uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_pressed   (s_pressed),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_index (m_out_index),
        .m_out_value (m_out_value)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Detector copy: settings and button/window state as the block keeps them
    // ------------------------------------------------------------------------
    logic [TIMEOUT_W-1:0]     set_timeout = TIMEOUT_RST;
    logic [OUTPUTS_W-1:0]     set_outputs = OUTPUTS_RST;
    logic                     btn_held    = 1'b0;
    logic                     long_hold   = 1'b0;
    logic                     win_open    = 1'b0;
    logic [COUNT_W-1:0]       presses     = '0;
    logic [TIME_BITS_DEF-1:0] ticks_since = '0;

    click_event_t expected_clicks [$];
    int           fail_count = 0;

    // Advance the detector copy by one beat and report the result it makes
    task automatic advance_detector(input logic cmd, input logic prs,
                                    output bit fires, output click_event_t ev);
        int n_out;
        int limit;
        int pick;
        fires = 1'b0;
        ev    = '0;
        // Outputs in use are clamped to 1..MAX for every decision
        n_out = (set_outputs < 1) ? 1 :
                (int'(set_outputs) > OUTS_MAX) ? OUTS_MAX : int'(set_outputs);
        if (cmd == CMD_SAMPLE) begin
            if (prs == BTN_DOWN) begin
                // A press opens the window or restarts its timer
                btn_held    = 1'b1;
                ticks_since = '0;
                if (!win_open) begin
                    win_open = 1'b1;
                    presses  = COUNT_W'(1);
                end else if (presses != '1) begin
                    presses++;
                end
            end else if (btn_held) begin
                btn_held = 1'b0;
                if (long_hold) begin
                    long_hold = 1'b0;
                    fires     = 1'b1;
                    ev.index  = '0;
                    ev.value  = 1'b0;
                end else if (n_out == 2) begin
                    fires    = 1'b1;
                    ev.index = INDEX_W'(1);
                    ev.value = 1'b1;
                end
            end
        end else if (win_open) begin
            // Ticks only count while a window is open
            if (ticks_since != '1)
                ticks_since++;
            limit = (set_timeout == 0) ? 1 : int'(set_timeout);
            if (limit > TIME_MAX)
                limit = TIME_MAX;
            if (int'(ticks_since) >= limit) begin
                pick = (int'(presses) >= n_out) ? n_out - 1 : int'(presses);
                if (btn_held) begin
                    long_hold = 1'b1;
                    pick      = 0;
                end
                win_open    = 1'b0;
                ticks_since = '0;
                if (long_hold || n_out > 2) begin
                    fires    = 1'b1;
                    ev.index = INDEX_W'(pick);
                    ev.value = 1'b1;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: track register writes, predict accepted beats, check results
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : watch
        bit           fires;
        click_event_t ev;
        click_event_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_TIMEOUT)
                    set_timeout = cfg_data[TIMEOUT_W-1:0];
                else if (cfg_index == REG_OUTPUTS)
                    set_outputs = cfg_data[OUTPUTS_W-1:0];
            end

            if (s_valid && s_ready) begin
                // Always advance the copy; a typed note overrides its result
                advance_detector(s_command, s_pressed, fires, ev);
                if (beat_note.kind == NOTE_FIRE) begin
                    want.index = beat_note.index;
                    want.value = beat_note.value;
                    expected_clicks.push_back(want);
                end else if (beat_note.kind == NOTE_PREDICT && fires) begin
                    expected_clicks.push_back(ev);
                end
            end

            if (m_valid && m_ready) begin
                if (expected_clicks.size() == 0) begin
                    $display("%0t: result beat with none expected: index %0d value %0b",
                             $time, m_out_index, m_out_value);
                    fail_count++;
                end else begin
                    want = expected_clicks.pop_front();
                    if (m_out_index !== want.index) begin
                        $display("%0t: out_index expected %0d got %0d",
                                 $time, want.index, m_out_index);
                        fail_count++;
                    end
                    if (m_out_value !== want.value) begin
                        $display("%0t: out_value expected %0b got %0b",
                                 $time, want.value, m_out_value);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Idling: a random wait before each beat, with calm stretches of none
    // ------------------------------------------------------------------------
    int send_calm = 0;
    int sink_calm = 0;

    function automatic int draw_pause(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            calm = $urandom_range(8, 40);
        return $urandom_range(0, 16);
    endfunction

    // Result side: drop ready for a random stall, then hold it until a beat moves
    initial begin : result_sink
        int pause;
        forever begin
            pause = draw_pause(sink_calm);
            if (pause > 0) begin
                m_ready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    int beats_sent = 0;
    int window_len = 1;

    // Drive one input beat and hold it until accepted. Valid drops only when
    // a gap follows, so it is never lowered and raised in one step.
    task automatic send_beat(input logic cmd, input logic prs, input note_t note);
        int pause;
        pause = draw_pause(send_calm);
        if (pause > 0) begin
            s_valid <= 1'b0;
            repeat (pause) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_pressed <= prs;
        beat_note <= note;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic tick_run(input int n);
        repeat (n) send_beat(CMD_TICK, 1'($urandom), BY_MODEL);
    endtask

    // Stop sending, let every result drain, then give the block time to settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_clicks.size() != 0) @(posedge aclk);
        repeat (HOLD_OFF) @(posedge aclk);
    endtask

    // One register write; the caller drops cfg_valid after the last of a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Reprogram both registers while idle; junk in the unused upper bits of
    // the outputs write must be ignored
    task automatic set_mode(input logic [TIMEOUT_W-1:0] tmo, input int outs,
                            input bit spare);
        wait_idle();
        write_reg(REG_TIMEOUT, CFG_DATA_W'(tmo));
        write_reg(REG_OUTPUTS, {(CFG_DATA_W-OUTPUTS_W)'($urandom), OUTPUTS_W'(outs)});
        if (spare)
            write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                      CFG_DATA_W'($urandom));
        cfg_valid  <= 1'b0;
        window_len = (tmo == 0) ? 1 : int'(tmo);
    endtask

    // A few clicks with short pauses, then let the window run out
    task automatic click_burst();
        int n_clicks;
        n_clicks = $urandom_range(1, 5);
        repeat (n_clicks) begin
            send_beat(CMD_SAMPLE, BTN_DOWN, BY_MODEL);
            tick_run($urandom_range(0, window_len / 2));
            send_beat(CMD_SAMPLE, BTN_UP, BY_MODEL);
            tick_run($urandom_range(0, window_len / 2));
        end
        tick_run(window_len + $urandom_range(0, 2));
    endtask

    // Hold past the window, sometimes press again while held, then release
    task automatic long_press();
        send_beat(CMD_SAMPLE, BTN_DOWN, BY_MODEL);
        tick_run(window_len + $urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0) begin
            send_beat(CMD_SAMPLE, BTN_DOWN, BY_MODEL);
            tick_run($urandom_range(0, window_len + 1));
        end
        send_beat(CMD_SAMPLE, BTN_UP, BY_MODEL);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int rand_end;
        int phase_end;
        int gesture;
        int tmo;
        int outs;

        // Hold reset once, at the start
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed script; register rows only touch an idle block
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (SCRIPT[r].kind == ROW_CFG) begin
                if (r == 0 || SCRIPT[r-1].kind != ROW_CFG)
                    wait_idle();
                write_reg(SCRIPT[r].reg_idx, SCRIPT[r].reg_data);
                if (r == NUM_ROWS - 1 || SCRIPT[r+1].kind != ROW_CFG)
                    cfg_valid <= 1'b0;
            end else begin
                send_beat(SCRIPT[r].cmd, SCRIPT[r].prs, SCRIPT[r].note);
            end
        end

        // Random phases, each under fresh settings
        rand_end = beats_sent + 1400;
        for (int phase = 0; beats_sent < rand_end; phase++) begin
            if (phase == 3) begin
                // Push the press count past its saturation point: a wrapping
                // counter would give a low index instead of the top one
                set_mode(TIMEOUT_W'(3), OUTS_MAX, 1'b0);
                repeat (260) begin
                    send_beat(CMD_SAMPLE, BTN_DOWN, BY_MODEL);
                    send_beat(CMD_SAMPLE, BTN_UP, BY_MODEL);
                end
                tick_run(window_len);
            end else if (phase == 6) begin
                // Longest timeout: the window must stay open; the next phase's
                // shorter setting closes it
                set_mode('1, $urandom_range(1, 4), 1'b1);
                send_beat(CMD_SAMPLE, BTN_DOWN, BY_MODEL);
                tick_run(40);
                send_beat(CMD_SAMPLE, BTN_UP, BY_MODEL);
                tick_run(20);
                send_beat(CMD_SAMPLE, BTN_DOWN, BY_MODEL);
                tick_run(20);
            end else begin
                case ($urandom_range(0, 9))
                    0:       tmo = 0;
                    1:       tmo = 1;
                    8, 9:    tmo = $urandom_range(9, 40);
                    default: tmo = $urandom_range(2, 8);
                endcase
                // Weight the mode boundaries: one, two, three and clamped counts
                case ($urandom_range(0, 7))
                    0:       outs = 2;
                    1:       outs = 3;
                    2:       outs = 1;
                    3:       outs = OUTS_MAX;
                    4:       outs = 0;
                    5:       outs = $urandom_range(OUTS_MAX + 1, OUTS_TOP);
                    default: outs = $urandom_range(1, OUTS_MAX);
                endcase
                set_mode(TIMEOUT_W'(tmo), outs, $urandom_range(0, 5) == 0);
                phase_end = beats_sent + $urandom_range(60, 140);
                while (beats_sent < phase_end) begin
                    gesture = $urandom_range(0, 9);
                    if (gesture < 5)
                        click_burst();
                    else if (gesture < 8)
                        long_press();
                    else
                        repeat ($urandom_range(1, 8))
                            send_beat(1'($urandom), 1'($urandom), BY_MODEL);
                end
            end
        end

        // Drain and report
        wait_idle();
        if (fail_count == 0 && expected_clicks.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
